FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define BRQ_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define BRQ_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");
`else
`define BRQ_ASSERT(label, clk, rst_n, prop)
`define BRQ_ASSERT_RST(label, clk, prop)
`endif

`endif

FILE: design/brq_pkg.sv
// ----------------------------------------------------------------------------
// Byte ring queue package
// Sizes, command codes and the beat descriptor of the byte ring queue.
// ----------------------------------------------------------------------------
`default_nettype none

package brq_pkg;

  localparam int unsigned DEPTH  = 256;
  localparam int unsigned LANES  = 8;
  localparam int unsigned PTR_W  = $clog2(DEPTH);
  localparam int unsigned LANE_W = $clog2(LANES);
  localparam int unsigned ROWS   = DEPTH / LANES;
  localparam int unsigned ROW_W  = PTR_W - LANE_W;
  localparam int unsigned CNT_W  = 8;
  localparam int unsigned TAKE_W = $clog2(LANES + 1);

  localparam logic [PTR_W-1:0]  MAX_LEVEL  = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0]  LANES_CNT  = CNT_W'(LANES);
  localparam logic [TAKE_W-1:0] FULL_BEAT  = TAKE_W'(LANES);

  localparam logic [2:0] CMD_PUSH      = 3'd0;
  localparam logic [2:0] CMD_PEEK      = 3'd1;
  localparam logic [2:0] CMD_POP       = 3'd2;
  localparam logic [2:0] CMD_POP_LAST  = 3'd3;
  localparam logic [2:0] CMD_WASTE     = 3'd4;
  localparam logic [2:0] CMD_WASTE_ALL = 3'd5;
  localparam logic [2:0] CMD_RESET     = 3'd6;

  typedef struct packed {
    logic [TAKE_W-1:0] lanes;
    logic [CNT_W-1:0]  done;
    logic              fin;
    logic [7:0]        level;
    logic [LANE_W-1:0] pos_lo;
  } beat_t;

endpackage

`default_nettype wire

FILE: design/byte_ring_queue_top.sv
// ----------------------------------------------------------------------------
// Byte ring queue
// 256-byte ring with eight interleaved byte banks, beat-wise read sequencer.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) takes one command word: cmd_i,
// count_i and eight push bytes, lane 0 oldest. Output channel
// (out_valid_o/out_ready_i) returns result words: eight read bytes,
// lane_count_o, done_count_o, final_beat_o and level_o.
// Push, waste, waste_all and reset give one result word each and are taken
// one per cycle while the output does not stall. Peek, pop and pop_last give
// ceil(n/8) beats (one if nothing is read); the command holds the input until
// its last beat is issued, as each byte bank has one read port (eight bytes
// per cycle while the output does not stall).
// A result is registered in the bank read stage, then in the output register.
// A stalled receiver holds the output register and the bank read stage;
// the input then stalls once both are full.
// Reset empties the queue (both pointers zero); bank contents are left
// unknown and are never read before being written.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module byte_ring_queue_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [2:0] cmd_i,
  input  wire logic [7:0] count_i,
  input  wire logic [7:0] in_byte0_i,
  input  wire logic [7:0] in_byte1_i,
  input  wire logic [7:0] in_byte2_i,
  input  wire logic [7:0] in_byte3_i,
  input  wire logic [7:0] in_byte4_i,
  input  wire logic [7:0] in_byte5_i,
  input  wire logic [7:0] in_byte6_i,
  input  wire logic [7:0] in_byte7_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte0_o,
  output logic [7:0]      out_byte1_o,
  output logic [7:0]      out_byte2_o,
  output logic [7:0]      out_byte3_o,
  output logic [7:0]      out_byte4_o,
  output logic [7:0]      out_byte5_o,
  output logic [7:0]      out_byte6_o,
  output logic [7:0]      out_byte7_o,
  output logic [3:0]      lane_count_o,
  output logic [7:0]      done_count_o,
  output logic            final_beat_o,
  output logic [7:0]      level_o
);

  localparam int unsigned PW = brq_pkg::PTR_W;
  localparam int unsigned LW = brq_pkg::LANE_W;
  localparam int unsigned CW = brq_pkg::CNT_W;
  localparam int unsigned TW = brq_pkg::TAKE_W;

  logic [PW-1:0] head_q, head_d, tail_q, tail_d;
  logic [PW-1:0] lvl, free_sp;
  logic [CW-1:0] lvl_cnt, min_n;
  logic [7:0]    in_lane [brq_pkg::LANES];

  logic          accept, is_read, push_ok;
  logic [PW-1:0] rd_start;
  logic [CW-1:0] rd_n, plain_done;

  logic          rd_busy_q, rd_busy_d;
  logic [PW-1:0] rd_pos_q, rd_pos_d;
  logic [CW-1:0] rd_left_q, rd_left_d, rd_done_q, rd_done_d;

  logic [PW-1:0] src_pos;
  logic [CW-1:0] src_left;
  logic [TW-1:0] take;
  logic          last, issue, slot_free, load_r;

  logic                  r_valid_q, r_valid_d;
  brq_pkg::beat_t        r_q, r_d;
  logic                  r_move, out_free;
  logic [brq_pkg::LANES-1:0][7:0] bank_rdata;

  logic       out_valid_q;
  logic [7:0] out_lane_q [brq_pkg::LANES];
  logic [7:0] out_lane_d [brq_pkg::LANES];
  brq_pkg::beat_t out_q;

  assign in_lane[0] = in_byte0_i;
  assign in_lane[1] = in_byte1_i;
  assign in_lane[2] = in_byte2_i;
  assign in_lane[3] = in_byte3_i;
  assign in_lane[4] = in_byte4_i;
  assign in_lane[5] = in_byte5_i;
  assign in_lane[6] = in_byte6_i;
  assign in_lane[7] = in_byte7_i;

  assign lvl     = tail_q - head_q;
  assign free_sp = brq_pkg::MAX_LEVEL - lvl;
  assign lvl_cnt = CW'(lvl);
  assign min_n   = (count_i < lvl_cnt) ? count_i : lvl_cnt;

  assign out_free   = !out_valid_q || out_ready_i;
  assign r_move     = r_valid_q && out_free;
  assign slot_free  = !r_valid_q || r_move;
  assign in_ready_o = !rd_busy_q && slot_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    is_read    = 1'b0;
    push_ok    = 1'b0;
    rd_start   = head_q;
    rd_n       = '0;
    plain_done = '0;
    if (accept) begin
      case (cmd_i)
        brq_pkg::CMD_PUSH: begin
          push_ok = (count_i <= brq_pkg::LANES_CNT) && (count_i <= CW'(free_sp));
          if (push_ok) begin
            tail_d     = tail_q + PW'(count_i);
            plain_done = count_i;
          end
        end
        brq_pkg::CMD_PEEK: begin
          is_read = 1'b1;
          rd_n    = min_n;
        end
        brq_pkg::CMD_POP: begin
          is_read = 1'b1;
          rd_n    = min_n;
          head_d  = head_q + PW'(min_n);
        end
        brq_pkg::CMD_POP_LAST: begin
          if (lvl_cnt >= count_i) begin
            is_read  = 1'b1;
            rd_n     = count_i;
            rd_start = head_q + PW'(lvl_cnt - count_i);
            head_d   = tail_q;
          end
        end
        brq_pkg::CMD_WASTE: begin
          head_d     = head_q + PW'(min_n);
          plain_done = min_n;
        end
        brq_pkg::CMD_WASTE_ALL: begin
          head_d     = tail_q;
          plain_done = lvl_cnt;
        end
        brq_pkg::CMD_RESET: begin
          head_d = '0;
          tail_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign src_pos  = rd_busy_q ? rd_pos_q : rd_start;
  assign src_left = rd_busy_q ? rd_left_q : rd_n;
  assign take     = (src_left < brq_pkg::LANES_CNT) ? TW'(src_left) : brq_pkg::FULL_BEAT;
  assign last     = (src_left <= brq_pkg::LANES_CNT);
  assign issue    = slot_free && (rd_busy_q || (accept && is_read));
  assign load_r   = slot_free && (rd_busy_q || accept);

  always_comb begin
    rd_busy_d = rd_busy_q;
    rd_pos_d  = rd_pos_q;
    rd_left_d = rd_left_q;
    rd_done_d = rd_done_q;
    if (accept && is_read) begin
      rd_done_d = rd_n;
    end
    if (issue) begin
      rd_busy_d = !last;
      rd_pos_d  = src_pos + PW'(take);
      rd_left_d = src_left - CW'(take);
    end
  end

  always_comb begin
    r_valid_d = r_valid_q;
    r_d       = r_q;
    if (r_move) begin
      r_valid_d = 1'b0;
    end
    if (load_r) begin
      r_valid_d = 1'b1;
      r_d.level = 8'(tail_d - head_d);
      if (issue) begin
        r_d.lanes  = take;
        r_d.done   = rd_busy_q ? rd_done_q : rd_n;
        r_d.fin    = last;
        r_d.pos_lo = src_pos[LW-1:0];
      end else begin
        r_d.lanes  = '0;
        r_d.done   = plain_done;
        r_d.fin    = 1'b1;
        r_d.pos_lo = '0;
      end
    end
  end

  for (genvar b = 0; b < brq_pkg::LANES; b++) begin : g_bank
    logic [7:0]            bank_q [brq_pkg::ROWS];
    logic [7:0]            rdata_q;
    logic [LW-1:0]         wk, rk;
    logic [PW-1:0]         w_addr, r_addr;
    logic                  we;

    assign wk     = LW'(b) - tail_q[LW-1:0];
    assign w_addr = tail_q + PW'(wk);
    assign we     = push_ok && (CW'(wk) < count_i);
    assign rk     = LW'(b) - src_pos[LW-1:0];
    assign r_addr = src_pos + PW'(rk);

    always_ff @(posedge clk_i) begin
      if (we) begin
        bank_q[w_addr[PW-1:LW]] <= in_lane[wk];
      end
      if (issue) begin
        rdata_q <= bank_q[r_addr[PW-1:LW]];
      end
    end

    assign bank_rdata[b] = rdata_q;
  end

  always_comb begin
    for (int i = 0; i < brq_pkg::LANES; i++) begin
      out_lane_d[i] = (TW'(i) < r_q.lanes) ? bank_rdata[LW'(r_q.pos_lo + LW'(i))] : 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      rd_busy_q   <= 1'b0;
      r_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      rd_busy_q <= rd_busy_d;
      r_valid_q <= r_valid_d;
      if (out_free) begin
        out_valid_q <= r_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_pos_q  <= rd_pos_d;
    rd_left_q <= rd_left_d;
    rd_done_q <= rd_done_d;
    r_q       <= r_d;
    if (r_move) begin
      out_q      <= r_q;
      out_lane_q <= out_lane_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte0_o  = out_lane_q[0];
  assign out_byte1_o  = out_lane_q[1];
  assign out_byte2_o  = out_lane_q[2];
  assign out_byte3_o  = out_lane_q[3];
  assign out_byte4_o  = out_lane_q[4];
  assign out_byte5_o  = out_lane_q[5];
  assign out_byte6_o  = out_lane_q[6];
  assign out_byte7_o  = out_lane_q[7];
  assign lane_count_o = out_q.lanes;
  assign done_count_o = out_q.done;
  assign final_beat_o = out_q.fin;
  assign level_o      = out_q.level;

  `BRQ_ASSERT(a_mid_beat_full, clk_i, rst_ni, out_valid_o && !final_beat_o |-> lane_count_o == brq_pkg::FULL_BEAT)
  `BRQ_ASSERT(a_next_beat_ready, clk_i, rst_ni, out_valid_o && !final_beat_o |=> out_valid_o)
  `BRQ_ASSERT(a_ptrs_hold_in_read, clk_i, rst_ni, rd_busy_q |=> $stable(head_q) && $stable(tail_q))
  `BRQ_ASSERT(a_beat_behind_out, clk_i, rst_ni, out_valid_o && !final_beat_o |-> r_valid_q || rd_busy_q)

endmodule

`default_nettype wire
